### rtl/tobp_pkg.sv
// Shared types, constants and codes for the tree object byte parser.
package tobp_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int HASH_BYTES  = 32;
  localparam int NAME_CAP    = 256;
  localparam int MODE_CAP    = 16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  // widest part limit sets the position counter width
  localparam int POS_LIM_MH = (MODE_CAP > HASH_BYTES) ? MODE_CAP : HASH_BYTES;
  localparam int POS_LIM    = (NAME_CAP > POS_LIM_MH) ? NAME_CAP : POS_LIM_MH;
  localparam int POS_W      = (POS_LIM > 2) ? $clog2(POS_LIM) : 1;
  localparam int ENT_W      = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    PH_MODE = 4'b0001,
    PH_NAME = 4'b0010,
    PH_HASH = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_MODE  = 3'd0,
    ROLE_SPACE = 3'd1,
    ROLE_NAME  = 3'd2,
    ROLE_TERM  = 3'd3,
    ROLE_HASH  = 3'd4,
    ROLE_IGN   = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MODE_LONG = 2'd1,
    ST_NAME_LONG = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [31:0]      acc;
    logic             frozen;
    logic [ENT_W-1:0] ent;
    status_t          err;
  } state_t;

  typedef struct packed {
    role_t       role;
    logic [7:0]  offset;
    logic [10:0] index;
    logic [31:0] mode;
    logic        done;
    status_t     status;
    logic [10:0] total;
  } result_t;

  localparam state_t STATE_CLEAR = '{
    phase:  PH_MODE,
    pos:    '0,
    acc:    '0,
    frozen: 1'b0,
    ent:    '0,
    err:    ST_OK
  };

endpackage

### rtl/tree_object_byte_parser_unit.sv
// Top level of the tree object byte parser: input register, parse step, result register.
//
// Streaming parser for serialized tree objects, one byte per transaction. Each entry
// is an octal mode ended by a space, a name ended by a zero byte, then a fixed-length
// hash; every byte comes back tagged with its role, its offset in its part and its
// entry index, and the last hash byte of an entry also carries the parsed mode.
// Throughput is one byte per clock unless the sink stalls: a byte is captured in the
// input register, then the parse step updates the parser state and loads the result
// register once that register is free, and the result is held there until it is taken.
// The parser state is read and written in that one step, which is what allows a new
// byte every cycle. Both registers advance whenever the result register is empty or
// being taken, so input ready only falls when a result is held back by the sink.
// Status and entry_total on the byte flagged last_byte are final for that object;
// all parser state is cleared after it.
module tree_object_byte_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  echo_byte,
  output logic [2:0]  role,
  output logic [7:0]  field_offset,
  output logic [10:0] entry_index,
  output logic [31:0] mode_value,
  output logic        entry_done,
  output logic        object_done,
  output logic [1:0]  status,
  output logic [10:0] entry_total
);
  import tobp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // parser state
  state_t  st;
  state_t  st_next;
  result_t res;

  logic s1_advance;
  logic in_take;

  // result register frees up when empty or its transaction completes
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_take    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= byte_value;
      s1_last <= last_byte;
    end
  end

  tobp_step u_step (
    .st         (st),
    .byte_value (s1_byte),
    .last_byte  (s1_last),
    .st_next    (st_next),
    .res        (res)
  );

  // state only moves when a byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      echo_byte    <= s1_byte;
      role         <= res.role;
      field_offset <= res.offset;
      entry_index  <= res.index;
      mode_value   <= res.mode;
      entry_done   <= res.done;
      object_done  <= s1_last;
      status       <= res.status;
      entry_total  <= res.total;
    end
  end

  // a completed entry is always a hash byte
  a_done_is_hash: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_done |-> role == ROLE_HASH)
    else $error("entry_done on a non-hash byte");

  // the running total moves by exactly the completed entry
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_total == entry_index + 11'(entry_done))
    else $error("entry_total out of step with entry_index");

  // ignored bytes carry no offset
  a_ign_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && role == ROLE_IGN |-> field_offset == 8'd0)
    else $error("offset on an ignored byte");

  // parser state is cleared after the last byte of an object
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_last |=> st == STATE_CLEAR)
    else $error("state not cleared after last byte");

  // mode is only reported with a completed entry
  a_mode_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_done |-> mode_value == 32'd0)
    else $error("mode_value without entry_done");

endmodule

### rtl/tobp_step.sv
// Per-byte parse step: next state and tagged result from current state and byte.
module tobp_step (
  input  tobp_pkg::state_t  st,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  output tobp_pkg::state_t  st_next,
  output tobp_pkg::result_t res
);
  import tobp_pkg::*;

  logic [POS_W-1:0] offset;
  logic [ENT_W-1:0] ent_inc;
  logic             is_digit;
  logic             partial;
  state_t           upd;

  assign is_digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_SEVEN);
  assign ent_inc  = st.ent + ENT_W'(1);

  always_comb begin
    upd        = st;
    offset     = '0;
    res.role   = ROLE_IGN;
    res.mode   = '0;
    res.done   = 1'b0;
    if (st.err == ST_OK) begin
      case (st.phase)
        PH_MODE: begin
          offset = st.pos;
          if (byte_value == CHAR_SPACE) begin
            res.role  = ROLE_SPACE;
            upd.phase = PH_NAME;
            upd.pos   = '0;
          end else begin
            res.role = ROLE_MODE;
            if (!st.frozen && is_digit) begin
              upd.acc = {st.acc[28:0], byte_value[2:0]};
            end else begin
              upd.frozen = 1'b1;
            end
            if (st.pos >= POS_W'(MODE_CAP - 1)) begin
              upd.err = ST_MODE_LONG;
            end else begin
              upd.pos = st.pos + POS_W'(1);
            end
          end
        end
        PH_NAME: begin
          offset = st.pos;
          if (byte_value == CHAR_NUL) begin
            res.role  = ROLE_TERM;
            upd.phase = PH_HASH;
            upd.pos   = '0;
          end else begin
            res.role = ROLE_NAME;
            if (st.pos >= POS_W'(NAME_CAP - 1)) begin
              upd.err = ST_NAME_LONG;
            end else begin
              upd.pos = st.pos + POS_W'(1);
            end
          end
        end
        PH_HASH: begin
          offset   = st.pos;
          res.role = ROLE_HASH;
          if (st.pos >= POS_W'(HASH_BYTES - 1)) begin
            res.done   = 1'b1;
            res.mode   = st.acc;
            upd.ent    = ent_inc;
            upd.pos    = '0;
            upd.acc    = '0;
            upd.frozen = 1'b0;
            upd.phase  = (ent_inc >= ENT_W'(MAX_ENTRIES)) ? PH_STOP : PH_MODE;
          end else begin
            upd.pos = st.pos + POS_W'(1);
          end
        end
        default: begin
          // entry limit reached: byte ignored
        end
      endcase
    end

    // object ending mid-entry without an earlier error
    partial = (upd.phase != PH_STOP) &&
              ((upd.phase != PH_MODE) || (upd.pos != '0));
    if (last_byte && (upd.err == ST_OK) && partial) begin
      upd.err = ST_TRUNC;
    end

    res.offset = 8'(offset);
    res.index  = 11'(st.ent);
    res.status = upd.err;
    res.total  = 11'(upd.ent);
    st_next    = last_byte ? STATE_CLEAR : upd;
  end

endmodule

### tb/sv/tree_object_byte_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tree object byte parser: byte stimulus, parser predictor, scoreboard.
module tree_object_byte_parser_unit_tb;
  import tobp_pkg::*;

  // Run bounds. A correct run is about two thousand bytes, even under the heaviest
  // stalls; the limit leaves a wide margin over that.
  localparam int unsigned RUN_LIMIT     = 60000;
  localparam int unsigned BYTES_PER_MIX = 440;  // random bytes per idling mix
  localparam int unsigned DRAIN_CYCLES  = 12;   // slack after the queue of owed bytes empties

  // One tagged byte as it leaves the block.
  typedef struct {
    logic [7:0]  echo;
    role_t       role;
    logic [7:0]  offset;
    logic [10:0] index;
    logic [31:0] mode;
    logic        done;
    logic        obj_end;
    status_t     status;
    logic [10:0] total;
  } tagged_byte_t;

  // Parser predictor plus the queue of tagged bytes still owed by the block.
  class entry_scoreboard;
    phase_t       ph;
    int unsigned  pos;
    logic [31:0]  acc;
    bit           frozen;
    int unsigned  ents;
    status_t      err;
    tagged_byte_t expected_q[$];
    int unsigned  failures;
    int unsigned  bytes_checked;
    int unsigned  entries_seen;
    int unsigned  objects_seen;
    int unsigned  objects_flagged;

    function new();
      clear_parser();
      failures        = 0;
      bytes_checked   = 0;
      entries_seen    = 0;
      objects_seen    = 0;
      objects_flagged = 0;
    endfunction

    function void clear_parser();
      ph     = PH_MODE;
      pos    = 0;
      acc    = '0;
      frozen = 1'b0;
      ents   = 0;
      err    = ST_OK;
    endfunction

    // Work out the tagged byte for one accepted input transaction.
    function void note_byte(logic [7:0] b, logic l);
      tagged_byte_t e;
      e.echo    = b;
      e.role    = ROLE_IGN;
      e.offset  = 8'd0;
      e.index   = ents[10:0];
      e.mode    = '0;
      e.done    = 1'b0;
      e.obj_end = l;
      if (err == ST_OK && ph == PH_MODE) begin
        e.offset = pos[7:0];
        if (b == CHAR_SPACE) begin
          e.role = ROLE_SPACE;
          ph     = PH_NAME;
          pos    = 0;
        end else begin
          e.role = ROLE_MODE;
          if (!frozen && b >= CHAR_ZERO && b <= CHAR_SEVEN)
            acc = {acc[28:0], b[2:0]};
          else
            frozen = 1'b1;
          if (pos >= MODE_CAP - 1)
            err = ST_MODE_LONG;
          else
            pos++;
        end
      end else if (err == ST_OK && ph == PH_NAME) begin
        e.offset = pos[7:0];
        if (b == CHAR_NUL) begin
          e.role = ROLE_TERM;
          ph     = PH_HASH;
          pos    = 0;
        end else begin
          e.role = ROLE_NAME;
          if (pos >= NAME_CAP - 1)
            err = ST_NAME_LONG;
          else
            pos++;
        end
      end else if (err == ST_OK && ph == PH_HASH) begin
        e.role   = ROLE_HASH;
        e.offset = pos[7:0];
        if (pos >= HASH_BYTES - 1) begin
          e.done = 1'b1;
          e.mode = acc;
          ents++;
          pos    = 0;
          acc    = '0;
          frozen = 1'b0;
          ph     = (ents >= MAX_ENTRIES) ? PH_STOP : PH_MODE;
          entries_seen++;
        end else begin
          pos++;
        end
      end
      if (l && err == ST_OK && ph != PH_STOP && (ph != PH_MODE || pos != 0))
        err = ST_TRUNC;
      e.status = err;
      e.total  = ents[10:0];
      expected_q.push_back(e);
      if (l) begin
        objects_seen++;
        if (err != ST_OK)
          objects_flagged++;
        clear_parser();
      end
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        failures++;
        $display("%0t: byte %0d %s mismatch, expected %0h, actual %0h",
                 $time, bytes_checked, what, want, seen);
      end
    endfunction

    // Check one result transaction against the oldest owed byte.
    function void check_result(tagged_byte_t got);
      tagged_byte_t e;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: result with nothing outstanding, expected none, actual echo %0h role %0d",
                 $time, got.echo, got.role);
        return;
      end
      e = expected_q.pop_front();
      compare_field("echo_byte",    e.echo,    got.echo);
      compare_field("role",         e.role,    got.role);
      compare_field("field_offset", e.offset,  got.offset);
      compare_field("entry_index",  e.index,   got.index);
      compare_field("mode_value",   e.mode,    got.mode);
      compare_field("entry_done",   e.done,    got.done);
      compare_field("object_done",  e.obj_end, got.obj_end);
      compare_field("status",       e.status,  got.status);
      compare_field("entry_total",  e.total,   got.total);
      bytes_checked++;
    endfunction
  endclass

  // Every block input holds a known value from time zero.
  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [7:0]  byte_value = 8'd0;
  logic        last_byte  = 1'b0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  echo_byte;
  logic [2:0]  role;
  logic [7:0]  field_offset;
  logic [10:0] entry_index;
  logic [31:0] mode_value;
  logic        entry_done;
  logic        object_done;
  logic [1:0]  status;
  logic [10:0] entry_total;

  int unsigned     send_idle   = 22;  // chance in a hundred of a gap before a byte
  int unsigned     recv_idle   = 65;  // chance in a hundred of out_ready low
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent  = 0;
  logic [7:0]      obj_bytes[$];      // object being assembled before it is streamed
  entry_scoreboard sb;

  tree_object_byte_parser_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_value   (byte_value),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .echo_byte    (echo_byte),
    .role         (role),
    .field_offset (field_offset),
    .entry_index  (entry_index),
    .mode_value   (mode_value),
    .entry_done   (entry_done),
    .object_done  (object_done),
    .status       (status),
    .entry_total  (entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a run that has not drained by the limit has hung somewhere.
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Sink back-pressure: one fresh decision per edge, at the current idling mix.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Inputs only move at rising edges, so handshake signals seen at the falling edge
  // are exactly what the next rising edge will act on. A result with valid and ready
  // both high here is taken at that edge.
  always @(negedge clk) begin : result_monitor
    tagged_byte_t got;
    if (!rst && out_valid && out_ready) begin
      got.echo    = echo_byte;
      got.role    = role_t'(role);
      got.offset  = field_offset;
      got.index   = entry_index;
      got.mode    = mode_value;
      got.done    = entry_done;
      got.obj_end = object_done;
      got.status  = status_t'(status);
      got.total   = entry_total;
      sb.check_result(got);
    end
  end

  // Offer one byte, possibly after a random gap, and hold it until the transaction
  // completes. Returns in the time step of the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= l;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_byte(b, l);
    bytes_sent++;
  endtask

  // Stream the assembled object; last_byte goes with its final byte.
  task automatic ship_object();
    foreach (obj_bytes[i])
      send_byte(obj_bytes[i], i == obj_bytes.size() - 1);
    obj_bytes.delete();
  endtask

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++)
      obj_bytes.push_back(s[k]);
  endfunction

  function automatic void push_fill(logic [7:0] v, int n);
    repeat (n) obj_bytes.push_back(v);
  endfunction

  // Any byte value at all; also used for hash bytes.
  function automatic void push_noise(int n);
    repeat (n) obj_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Octal digits; with odd set, roughly one in four is some other non-space byte.
  function automatic void push_mode(int digits, bit odd);
    logic [7:0] c;
    repeat (digits) begin
      c = CHAR_ZERO + 8'($urandom_range(7));
      if (odd && $urandom_range(3) == 0) begin
        c = 8'($urandom_range(255));
        if (c == CHAR_SPACE)
          c = CHAR_SEVEN + 8'd1;
      end
      obj_bytes.push_back(c);
    end
  endfunction

  function automatic void push_name(int len);
    repeat (len) obj_bytes.push_back(8'($urandom_range(1, 255)));
  endfunction

  // A complete, well-formed entry.
  function automatic void add_entry(int digit_count, int label_len, bit odd);
    push_mode(digit_count, odd);
    obj_bytes.push_back(CHAR_SPACE);
    push_name(label_len);
    obj_bytes.push_back(CHAR_NUL);
    push_noise(HASH_BYTES);
  endfunction

  // Mostly well-formed objects of one to three entries with random content; the rest
  // are cut short, overrun a part limit, or are plain noise.
  function automatic void build_random_object();
    int kind;
    int cut;
    kind = $urandom_range(99);
    if (kind < 85) begin
      repeat ($urandom_range(1, 3))
        add_entry(($urandom_range(3) == 0) ? $urandom_range(MODE_CAP - 1) : $urandom_range(5, 6),
                  ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(1, 12),
                  $urandom_range(9) == 0);
      if (kind >= 70) begin
        // truncated: drop a random tail, keeping at least one byte
        cut = $urandom_range(1, obj_bytes.size() - 1);
        repeat (cut) void'(obj_bytes.pop_back());
      end
    end else if (kind < 93) begin
      if ($urandom_range(1) == 1)
        add_entry($urandom_range(1, 6), $urandom_range(1, 8), 1'b0);
      if ($urandom_range(3) != 0) begin
        push_mode($urandom_range(MODE_CAP, MODE_CAP + 4), 1'b0);
      end else begin
        obj_bytes.push_back(CHAR_SPACE);
        push_name($urandom_range(NAME_CAP, NAME_CAP + 3));
      end
      push_noise($urandom_range(8));
    end else begin
      push_noise($urandom_range(1, 40));
    end
  endfunction

  task automatic random_objects(int unsigned quota);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      build_random_object();
      ship_object();
    end
  endtask

  // Hand-picked objects: field extremes, every role, each error and the truncation cases.
  task automatic directed_objects();
    // two ordinary entries, hash bytes all ones then all zeros
    push_text("100644 readme");
    obj_bytes.push_back(CHAR_NUL);
    push_fill(8'hFF, HASH_BYTES);
    push_text("40000 src");
    obj_bytes.push_back(CHAR_NUL);
    push_fill(8'h00, HASH_BYTES);
    ship_object();
    // empty mode and empty name
    add_entry(0, 0, 1'b0);
    ship_object();
    // longest legal mode of sevens: accumulator wraps past 32 bits
    push_fill(CHAR_SEVEN, MODE_CAP - 1);
    push_text(" x");
    obj_bytes.push_back(CHAR_NUL);
    push_noise(HASH_BYTES);
    ship_object();
    // accumulation freezes at the first non-octal byte; a zero byte is still a mode byte
    push_text("12");
    obj_bytes.push_back(CHAR_SEVEN + 8'd2);
    obj_bytes.push_back(CHAR_NUL);
    push_text("7 n");
    obj_bytes.push_back(CHAR_NUL);
    push_noise(HASH_BYTES);
    ship_object();
    // mode too long, then the rest is ignored
    push_fill(CHAR_ZERO + 8'd1, MODE_CAP);
    push_text(" ab");
    ship_object();
    // name too long, then the rest is ignored
    obj_bytes.push_back(CHAR_SPACE);
    push_name(NAME_CAP);
    obj_bytes.push_back(CHAR_NUL);
    push_noise(3);
    ship_object();
    // truncation: last byte is a lone space, a lone digit, a terminator, mid-hash
    obj_bytes.push_back(CHAR_SPACE);
    ship_object();
    push_text("6");
    ship_object();
    push_text("644 f");
    obj_bytes.push_back(CHAR_NUL);
    ship_object();
    add_entry(6, 4, 1'b0);
    repeat (5) void'(obj_bytes.pop_back());
    ship_object();
    // a whole entry followed by one stray mode byte
    add_entry(6, 4, 1'b0);
    push_text("1");
    ship_object();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender gaps 22 %, sink stalls 65 %
    directed_objects();
    random_objects(BYTES_PER_MIX);

    // the other way round
    send_idle = 65;
    recv_idle = 22;
    random_objects(BYTES_PER_MIX);

    // no idling at either side
    send_idle = 0;
    recv_idle = 0;
    random_objects(BYTES_PER_MIX);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d tagged bytes over %0d objects: %0d entries completed, %0d flagged.",
             sb.bytes_checked, sb.objects_seen, sb.entries_seen, sb.objects_flagged);
    $display("Idling mixes 22/65, 65/22 and none; every role, each error and truncation hit.");
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
